>>> sv/ldri_pkg.sv
// ldri_pkg: shared types and constants of the depth-aware remap interpolator
// no dependencies; imported by every module of the block

package ldri_pkg;

  // lanes, one per source neighbor (top left first)
  localparam int unsigned NUM_LANES = 4;

  // discontinuity ratio is Q0.16
  localparam int unsigned RATIO_FRAC_BITS = 16;
  localparam int unsigned RATIO_BITS      = 16;
  localparam int unsigned CFG_DATA_BITS   = 16;
  localparam int unsigned MODE_BITS       = 2;
  localparam int unsigned STATUS_BITS     = 2;

  // register indexes
  localparam logic REG_INTERP_MODE = 1'b0;
  localparam logic REG_SKIP_RATIO  = 1'b1;

  // interpolation modes; the unused fourth code acts as depth mode
  localparam logic [MODE_BITS-1:0] MODE_NEAREST  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_BILINEAR = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DEPTH    = 2'd2;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_WRITTEN = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ZERO    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_DISCONT = 2'd3;

  // register reset values
  localparam logic [MODE_BITS-1:0]  MODE_RESET  = MODE_DEPTH;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd3076;

  // per-request control that travels alongside the payload
  typedef struct packed {
    logic valid;
    logic entry_valid;
  } item_ctl_t;

endpackage

>>> sv/ldri_lane.sv
// ldri_lane: one neighbor lane, weight product and zero-depth flag, registered
// depends on ldri_pkg

module ldri_lane #(
  parameter int unsigned PIXEL_BITS       = 16,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic [PIXEL_BITS-1:0]                  nb_i,
  input  logic [WEIGHT_FRAC_BITS:0]              wt_i,
  output logic [PIXEL_BITS+WEIGHT_FRAC_BITS:0]   prod_r,
  output logic [PIXEL_BITS-1:0]                  nb_r,
  output logic                                   zero_r
);
  import ldri_pkg::*;

  localparam int unsigned PW = PIXEL_BITS + WEIGHT_FRAC_BITS + 1;

  // pixel times weight, plus zero detect for the depth check
  always_ff @(posedge clk) begin
    prod_r <= PW'(nb_i) * PW'(wt_i);
    nb_r   <= nb_i;
    zero_r <= (nb_i == '0);
  end

endmodule

>>> sv/ldri_merge.sv
// ldri_merge: combines the lane results into one pixel and status
// depends on ldri_pkg; fed by four ldri_lane instances

module ldri_merge #(
  parameter int unsigned PIXEL_BITS       = 16,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  ldri_pkg::item_ctl_t                                   ctl_i,
  input  logic [ldri_pkg::NUM_LANES-1:0][PIXEL_BITS+WEIGHT_FRAC_BITS:0] prod_i,
  input  logic [ldri_pkg::NUM_LANES-1:0][PIXEL_BITS-1:0]        nb_i,
  input  logic [ldri_pkg::NUM_LANES-1:0]                        zero_i,
  input  logic [ldri_pkg::MODE_BITS-1:0]                        mode_i,
  input  logic [ldri_pkg::RATIO_BITS-1:0]                       ratio_i,
  output logic                                                  out_valid,
  output logic [PIXEL_BITS-1:0]                                 out_pixel_out,
  output logic [ldri_pkg::STATUS_BITS-1:0]                      out_status
);
  import ldri_pkg::*;

  localparam int unsigned P  = PIXEL_BITS;
  localparam int unsigned W  = WEIGHT_FRAC_BITS;
  localparam int unsigned PW = P + W + 1;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned RW = RATIO_FRAC_BITS + P;
  localparam logic [SW-1:0] ROUND_HALF = SW'(1) << (W - 1);

  // min/max tree over the four neighbors
  logic [P-1:0] lo_a, lo_b, hi_a, hi_b, lo_c, hi_c;
  always_comb begin
    lo_a = (nb_i[0] < nb_i[1]) ? nb_i[0] : nb_i[1];
    hi_a = (nb_i[0] < nb_i[1]) ? nb_i[1] : nb_i[0];
    lo_b = (nb_i[2] < nb_i[3]) ? nb_i[2] : nb_i[3];
    hi_b = (nb_i[2] < nb_i[3]) ? nb_i[3] : nb_i[2];
    lo_c = (lo_a < lo_b) ? lo_a : lo_b;
    hi_c = (hi_a < hi_b) ? hi_b : hi_a;
  end

  // stage 1: pairwise sums, range, zero flag
  item_ctl_t     s1_ctl_r;
  logic [PW:0]   s1_p01_r, s1_p23_r;
  logic [P-1:0]  s1_lo_r, s1_hi_r, s1_tl_r;
  logic          s1_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= ctl_i;
    end
    s1_p01_r  <= (PW+1)'(prod_i[0]) + (PW+1)'(prod_i[1]);
    s1_p23_r  <= (PW+1)'(prod_i[2]) + (PW+1)'(prod_i[3]);
    s1_lo_r   <= lo_c;
    s1_hi_r   <= hi_c;
    s1_tl_r   <= nb_i[0];
    s1_zero_r <= |zero_i;
  end

  // stage 2: rounded total, spread and threshold product
  item_ctl_t     s2_ctl_r;
  logic [SW-1:0] s2_sum_r;
  logic [P-1:0]  s2_diff_r, s2_tl_r;
  logic [RW-1:0] s2_thr_r;
  logic          s2_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s1_ctl_r;
    end
    s2_sum_r  <= SW'(s1_p01_r) + SW'(s1_p23_r) + ROUND_HALF;
    s2_diff_r <= s1_hi_r - s1_lo_r;
    s2_thr_r  <= RW'(ratio_i) * RW'(s1_lo_r);
    s2_tl_r   <= s1_tl_r;
    s2_zero_r <= s1_zero_r;
  end

  // stage 3: saturate, discontinuity compare, final select
  logic [P+2:0]           pix_full;
  logic [P-1:0]           pix_sat;
  logic                   disc;
  logic                   chk_depth;
  logic [P-1:0]           pixel_nxt;
  logic [STATUS_BITS-1:0] status_nxt;

  always_comb begin
    pix_full   = s2_sum_r[SW-1:W];
    pix_sat    = (|pix_full[P+2:P]) ? '1 : pix_full[P-1:0];
    disc       = {s2_diff_r, {RATIO_FRAC_BITS{1'b0}}} > s2_thr_r;
    chk_depth  = (mode_i != MODE_NEAREST) && (mode_i != MODE_BILINEAR);
    pixel_nxt  = '0;
    status_nxt = ST_WRITTEN;
    if (!s2_ctl_r.entry_valid) begin
      status_nxt = ST_INVALID;
    end else if (mode_i == MODE_NEAREST) begin
      pixel_nxt = s2_tl_r;
    end else if (chk_depth && s2_zero_r) begin
      status_nxt = ST_ZERO;
    end else if (chk_depth && disc) begin
      status_nxt = ST_DISCONT;
    end else begin
      pixel_nxt = pix_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_ctl_r.valid;
    end
    out_pixel_out <= pixel_nxt;
    out_status    <= status_nxt;
  end

  // a request in stage 1 reaches stage 2 next cycle
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctl_r.valid |=> s2_ctl_r.valid)
    else $error("request lost between stage 1 and stage 2");

  // a rejected pixel always reads zero
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_WRITTEN) |-> out_pixel_out == '0)
    else $error("rejected pixel is not zero");

  // depth rejections only come out of depth mode
  a_depth_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_ZERO) || (out_status == ST_DISCONT))
      |-> (mode_i != MODE_NEAREST) && (mode_i != MODE_BILINEAR))
    else $error("depth rejection outside depth mode");

endmodule

>>> sv/lut_depth_remap_interpolator_top.sv
// lut_depth_remap_interpolator_top: depth-aware bilinear remap interpolator
// depends on ldri_pkg, ldri_lane and ldri_merge
//
//   channel   ports                         handshake
//   request   start, busy, in_*             taken when start && !busy
//   result    out_valid, out_*              one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_idx, cfg_wdata    written when cfg_we
//
// one request per clock; the result strobe is registered through four
// register stages: lane multiply, pair sums, total and ratio multiply,
// compare and select
// busy stays low: the pipeline has no stalls and the receiver cannot hold off
// synchronous active-low reset clears pipeline valids and loads mode 2,
// ratio 3076

module lut_depth_remap_interpolator_top #(
  parameter int unsigned PIXEL_BITS       = 16,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_entry_valid,
  input  logic [PIXEL_BITS-1:0]                  in_neighbor_tl,
  input  logic [PIXEL_BITS-1:0]                  in_neighbor_tr,
  input  logic [PIXEL_BITS-1:0]                  in_neighbor_bl,
  input  logic [PIXEL_BITS-1:0]                  in_neighbor_br,
  input  logic [WEIGHT_FRAC_BITS:0]              in_weight_tl,
  input  logic [WEIGHT_FRAC_BITS:0]              in_weight_tr,
  input  logic [WEIGHT_FRAC_BITS:0]              in_weight_bl,
  input  logic [WEIGHT_FRAC_BITS:0]              in_weight_br,
  // result
  output logic                                   out_valid,
  output logic [PIXEL_BITS-1:0]                  out_pixel_out,
  output logic [ldri_pkg::STATUS_BITS-1:0]       out_status,
  // configuration
  input  logic                                   cfg_we,
  input  logic                                   cfg_idx,
  input  logic [ldri_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
  import ldri_pkg::*;

  localparam int unsigned PW = PIXEL_BITS + WEIGHT_FRAC_BITS + 1;

  // configuration registers
  logic [MODE_BITS-1:0]  interp_mode_r;
  logic [RATIO_BITS-1:0] skip_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_mode_r <= MODE_RESET;
      skip_ratio_r  <= RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_INTERP_MODE: interp_mode_r <= cfg_wdata[MODE_BITS-1:0];
        REG_SKIP_RATIO:  skip_ratio_r  <= cfg_wdata[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline never stalls
  assign busy = 1'b0;

  // lane operands, top left first
  logic [NUM_LANES-1:0][PIXEL_BITS-1:0]     nb;
  logic [NUM_LANES-1:0][WEIGHT_FRAC_BITS:0] wt;
  logic [NUM_LANES-1:0][PW-1:0]             prod;
  logic [NUM_LANES-1:0][PIXEL_BITS-1:0]     nb_q;
  logic [NUM_LANES-1:0]                     zero_q;

  assign nb = {in_neighbor_br, in_neighbor_bl, in_neighbor_tr, in_neighbor_tl};
  assign wt = {in_weight_br, in_weight_bl, in_weight_tr, in_weight_tl};

  // control alongside the lane stage
  item_ctl_t ctl0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r.valid       <= start && !busy;
      ctl0_r.entry_valid <= in_entry_valid;
    end
  end

  // four lanes in parallel
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ldri_lane #(
      .PIXEL_BITS       (PIXEL_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .nb_i   (nb[g]),
      .wt_i   (wt[g]),
      .prod_r (prod[g]),
      .nb_r   (nb_q[g]),
      .zero_r (zero_q[g])
    );
  end

  // merge stage
  ldri_merge #(
    .PIXEL_BITS       (PIXEL_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl_i         (ctl0_r),
    .prod_i        (prod),
    .nb_i          (nb_q),
    .zero_i        (zero_q),
    .mode_i        (interp_mode_r),
    .ratio_i       (skip_ratio_r),
    .out_valid     (out_valid),
    .out_pixel_out (out_pixel_out),
    .out_status    (out_status)
  );

endmodule

>>> test/lut_depth_remap_interpolator_top_test.sv
// lut_depth_remap_interpolator_top_test: self-checking bench for the depth-aware remap interpolator
// depends on ldri_pkg and lut_depth_remap_interpolator_top; predicts every pixel in-bench
// and compares each result strobe in order, across several mode and ratio settings

module lut_depth_remap_interpolator_top_test;

  import ldri_pkg::*;

  localparam int unsigned PIX_W       = 16;
  localparam int unsigned WFRAC       = 16;
  localparam int unsigned LAT_CYCLES  = 4;
  localparam int unsigned DRAIN_PAUSE = LAT_CYCLES + 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 225;

  localparam logic [PIX_W-1:0]     PIX_MAX    = '1;
  localparam logic [WFRAC:0]       WEIGHT_ONE = 17'd65536;
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic             entry_valid;
    logic [PIX_W-1:0] nb_tl;
    logic [PIX_W-1:0] nb_tr;
    logic [PIX_W-1:0] nb_bl;
    logic [PIX_W-1:0] nb_br;
    logic [WFRAC:0]   wt_tl;
    logic [WFRAC:0]   wt_tr;
    logic [WFRAC:0]   wt_bl;
    logic [WFRAC:0]   wt_br;
  } pixel_req_t;

  typedef struct packed {
    pixel_req_t req;
    logic [3:0] gap;
    logic       hold_for_drain;
  } pending_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]       pixel;
    logic [STATUS_BITS-1:0] status;
  } pixel_res_t;

  // dut ports
  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     start          = 1'b0;
  logic                     busy;
  logic                     in_entry_valid = 1'b0;
  logic [PIX_W-1:0]         in_neighbor_tl = '0;
  logic [PIX_W-1:0]         in_neighbor_tr = '0;
  logic [PIX_W-1:0]         in_neighbor_bl = '0;
  logic [PIX_W-1:0]         in_neighbor_br = '0;
  logic [WFRAC:0]           in_weight_tl   = '0;
  logic [WFRAC:0]           in_weight_tr   = '0;
  logic [WFRAC:0]           in_weight_bl   = '0;
  logic [WFRAC:0]           in_weight_br   = '0;
  logic                     out_valid;
  logic [PIX_W-1:0]         out_pixel_out;
  logic [STATUS_BITS-1:0]   out_status;
  logic                     cfg_we         = 1'b0;
  logic                     cfg_idx        = REG_INTERP_MODE;
  logic [CFG_DATA_BITS-1:0] cfg_wdata      = '0;

  // bench state
  pending_req_t           pend_q[$];
  pixel_res_t             pixel_exp_q[$];
  pending_req_t           next_req;
  pixel_res_t             want;
  pixel_req_t             seen_req;
  logic [MODE_BITS-1:0]   mode_copy  = MODE_RESET;
  logic [RATIO_BITS-1:0]  ratio_copy = RATIO_RESET;
  bit                     quiet      = 1'b1;
  int unsigned            idle_cnt   = 0;
  int unsigned            cycle_cnt  = 0;
  int unsigned            fail_cnt   = 0;

  wire req_taken = start && (busy === 1'b0);

  lut_depth_remap_interpolator_top #(
    .PIXEL_BITS       (PIX_W),
    .WEIGHT_FRAC_BITS (WFRAC)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_entry_valid (in_entry_valid),
    .in_neighbor_tl (in_neighbor_tl),
    .in_neighbor_tr (in_neighbor_tr),
    .in_neighbor_bl (in_neighbor_bl),
    .in_neighbor_br (in_neighbor_br),
    .in_weight_tl   (in_weight_tl),
    .in_weight_tr   (in_weight_tr),
    .in_weight_bl   (in_weight_bl),
    .in_weight_br   (in_weight_br),
    .out_valid      (out_valid),
    .out_pixel_out  (out_pixel_out),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected pixel and status for one request under the given settings
  function automatic pixel_res_t calc_pixel(pixel_req_t r, logic [MODE_BITS-1:0] mode,
                                            logic [RATIO_BITS-1:0] ratio);
    logic [PIX_W-1:0] nb [4];
    logic [WFRAC:0]   wt [4];
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [63:0]      acc;
    logic [63:0]      span;
    logic [63:0]      thresh;
    bit               zero_seen;
    pixel_res_t       res;
    nb = '{r.nb_tl, r.nb_tr, r.nb_bl, r.nb_br};
    wt = '{r.wt_tl, r.wt_tr, r.wt_bl, r.wt_br};
    res.pixel  = '0;
    res.status = ST_WRITTEN;
    acc        = '0;
    if (!r.entry_valid) begin
      res.status = ST_INVALID;
    end else if (mode == MODE_NEAREST) begin
      res.pixel = r.nb_tl;
    end else begin
      // depth checks; the spare mode code behaves as depth mode
      if (mode != MODE_BILINEAR) begin
        lo        = nb[0];
        hi        = nb[0];
        zero_seen = 1'b0;
        for (int k = 0; k < 4; k++) begin
          if (nb[k] == '0) zero_seen = 1'b1;
          if (nb[k] < lo) lo = nb[k];
          if (nb[k] > hi) hi = nb[k];
        end
        span   = 64'(hi - lo) << RATIO_FRAC_BITS;
        thresh = 64'(ratio) * 64'(lo);
        // zero neighbor wins over discontinuity
        if (zero_seen) res.status = ST_ZERO;
        else if (span > thresh) res.status = ST_DISCONT;
      end
      if (res.status == ST_WRITTEN) begin
        for (int k = 0; k < 4; k++) acc += 64'(nb[k]) * 64'(wt[k]);
        acc = (acc + (64'd1 << (WFRAC - 1))) >> WFRAC;
        res.pixel = (acc > 64'(PIX_MAX)) ? PIX_MAX : acc[PIX_W-1:0];
      end
    end
    return res;
  endfunction

  // random pixel request, mostly smooth depth patches so depth mode gets past its checks
  function automatic pixel_req_t rand_pixel(logic [RATIO_BITS-1:0] ratio);
    pixel_req_t        r;
    logic [PIX_W-1:0]  v [4];
    int unsigned       kind;
    int unsigned       width;
    longint unsigned   base;
    longint unsigned   spread;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   fx;
    longint unsigned   fy;
    longint unsigned   w_tl;
    longint unsigned   w_tr;
    longint unsigned   w_bl;
    kind = $urandom_range(0, 15);
    r.entry_valid = ($urandom_range(0, 9) != 0);
    case (kind)
      0: begin
        for (int k = 0; k < 4; k++) v[k] = PIX_W'($urandom_range(0, 65535));
      end
      1: begin
        for (int k = 0; k < 4; k++)
          v[k] = $urandom_range(0, 1) ? PIX_MAX : PIX_W'($urandom_range(0, 3));
      end
      2, 3: begin
        // straddle the discontinuity threshold
        lo = 64'($urandom_range(1, 65535));
        hi = lo + ((longint'(ratio) * lo) >> RATIO_FRAC_BITS) + 64'($urandom_range(0, 1));
        if (hi > 65535) hi = 65535;
        for (int k = 0; k < 4; k++) v[k] = $urandom_range(0, 1) ? PIX_W'(lo) : PIX_W'(hi);
        v[$urandom_range(0, 3)] = PIX_W'(hi);
        v[$urandom_range(0, 3)] = PIX_W'(lo);
      end
      default: begin
        width  = $urandom_range(1, 16);
        base   = 64'($urandom_range(1, (1 << width) - 1));
        spread = base >> $urandom_range(3, 12);
        for (int k = 0; k < 4; k++) begin
          hi = base + 64'($urandom_range(0, 32'(spread)));
          v[k] = (hi > 65535) ? PIX_MAX : hi[PIX_W-1:0];
        end
      end
    endcase
    if ($urandom_range(0, 9) == 0) v[$urandom_range(0, 3)] = '0;
    r.nb_tl = v[0];
    r.nb_tr = v[1];
    r.nb_bl = v[2];
    r.nb_br = v[3];
    if ($urandom_range(0, 7) == 0) begin
      // arbitrary weights, sums above one saturate
      r.wt_tl = (WFRAC+1)'($urandom_range(0, 65536));
      r.wt_tr = (WFRAC+1)'($urandom_range(0, 65536));
      r.wt_bl = (WFRAC+1)'($urandom_range(0, 65536));
      r.wt_br = (WFRAC+1)'($urandom_range(0, 65536));
    end else begin
      fx    = 64'($urandom_range(0, 65536));
      fy    = 64'($urandom_range(0, 65536));
      w_tl  = ((65536 - fx) * (65536 - fy)) >> WFRAC;
      w_tr  = (fx * (65536 - fy)) >> WFRAC;
      w_bl  = ((65536 - fx) * fy) >> WFRAC;
      r.wt_tl = (WFRAC+1)'(w_tl);
      r.wt_tr = (WFRAC+1)'(w_tr);
      r.wt_bl = (WFRAC+1)'(w_bl);
      r.wt_br = (WFRAC+1)'(65536 - w_tl - w_tr - w_bl);
    end
    return r;
  endfunction

  // directed request, no gap before it
  task automatic queue_pixel(input logic ev, input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] tr,
                             input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] br,
                             input logic [WFRAC:0] a, input logic [WFRAC:0] b,
                             input logic [WFRAC:0] c, input logic [WFRAC:0] d);
    pending_req_t e;
    e.req            = '{ev, tl, tr, bl, br, a, b, c, d};
    e.gap            = '0;
    e.hold_for_drain = 1'b0;
    pend_q = {pend_q, e};
  endtask

  // wait until every request is sent and answered, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    while (pend_q.size() != 0 || start || !quiet) @(negedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // write both registers while idle
  task automatic set_config(input logic [MODE_BITS-1:0] mode, input logic [RATIO_BITS-1:0] ratio);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_INTERP_MODE;
    cfg_wdata <= CFG_DATA_BITS'(mode);
    @(posedge clk);
    cfg_idx   <= REG_SKIP_RATIO;
    cfg_wdata <= ratio;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_copy  = mode;
    ratio_copy = ratio;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      idle_cnt <= 0;
    end else if (start && !req_taken) begin
      // hold the current request
    end else if (pend_q.size() != 0 && idle_cnt >= pend_q[0].gap &&
                 (!pend_q[0].hold_for_drain || (quiet && !start))) begin
      next_req = pend_q.pop_front();
      start          <= 1'b1;
      in_entry_valid <= next_req.req.entry_valid;
      in_neighbor_tl <= next_req.req.nb_tl;
      in_neighbor_tr <= next_req.req.nb_tr;
      in_neighbor_bl <= next_req.req.nb_bl;
      in_neighbor_br <= next_req.req.nb_br;
      in_weight_tl   <= next_req.req.wt_tl;
      in_weight_tr   <= next_req.req.wt_tr;
      in_weight_bl   <= next_req.req.wt_bl;
      in_weight_br   <= next_req.req.wt_br;
      idle_cnt       <= 0;
    end else begin
      start <= 1'b0;
      if (idle_cnt < 15) idle_cnt <= idle_cnt + 1;
    end
  end

  // result monitor: predict on each taken request, compare each strobe in order
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 1'b1;
    end else begin
      if (req_taken) begin
        seen_req = '{in_entry_valid, in_neighbor_tl, in_neighbor_tr, in_neighbor_bl,
                     in_neighbor_br, in_weight_tl, in_weight_tr, in_weight_bl, in_weight_br};
        pixel_exp_q = {pixel_exp_q, calc_pixel(seen_req, mode_copy, ratio_copy)};
      end
      if (out_valid === 1'b1) begin
        if (pixel_exp_q.size() == 0) begin
          $error("result with no request pending: pixel_out %0d status %0d",
                 out_pixel_out, out_status);
          fail_cnt++;
        end else begin
          want = pixel_exp_q.pop_front();
          if (out_pixel_out !== want.pixel) begin
            $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, out_pixel_out);
            fail_cnt++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            fail_cnt++;
          end
        end
      end
      quiet <= (pixel_exp_q.size() == 0);
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** lut_depth_remap_interpolator_top: FAILED **");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    pending_req_t          e;
    logic [MODE_BITS-1:0]  mode;
    logic [RATIO_BITS-1:0] ratio;
    int unsigned           style;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // register reset values: depth mode, default ratio
    @(negedge clk);
    queue_pixel(1'b0, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE,
                WEIGHT_ONE);
    queue_pixel(1'b1, 1000, 1000, 1000, 1000, 16384, 16384, 16384, 16384);
    // zero neighbor together with a wide span
    queue_pixel(1'b1, 0, 60000, 60000, 60000, 16384, 16384, 16384, 16384);
    queue_pixel(1'b1, 500, 500, 500, 0, 16384, 16384, 16384, 16384);
    queue_pixel(1'b1, 1000, 2000, 1000, 1000, 16384, 16384, 16384, 16384);
    // just under and just over the discontinuity threshold
    queue_pixel(1'b1, 64, 67, 64, 64, 16384, 16384, 16384, 16384);
    queue_pixel(1'b1, 64, 64, 64, 68, 16384, 16384, 16384, 16384);
    queue_pixel(1'b1, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE,
                WEIGHT_ONE);
    // rounding at exactly one half and just below
    queue_pixel(1'b1, 1, 1, 1, 1, 32768, 0, 0, 0);
    queue_pixel(1'b1, 1, 1, 1, 1, 32767, 0, 0, 0);
    queue_pixel(1'b1, 5000, 5000, 5000, 5000, 0, 0, 0, 0);
    wait_idle();

    // nearest neighbor ignores the rest
    set_config(MODE_NEAREST, 16'd0);
    @(negedge clk);
    queue_pixel(1'b1, 0, PIX_MAX, 1, 2, WEIGHT_ONE, 0, 0, 0);
    queue_pixel(1'b1, PIX_MAX, 0, 0, 0, 0, 0, 0, 0);
    queue_pixel(1'b0, 1234, 1, 2, 3, 0, WEIGHT_ONE, 0, 0);
    wait_idle();

    // plain bilinear takes zeros and wide spans
    set_config(MODE_BILINEAR, 16'hFFFF);
    @(negedge clk);
    queue_pixel(1'b1, 0, PIX_MAX, 0, PIX_MAX, 16384, 16384, 16384, 16384);
    queue_pixel(1'b1, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE,
                WEIGHT_ONE);
    queue_pixel(1'b1, 1, PIX_MAX, 1, 1, 0, WEIGHT_ONE, 0, 0);
    wait_idle();

    // spare mode code with the largest ratio
    set_config(MODE_SPARE, 16'hFFFF);
    @(negedge clk);
    queue_pixel(1'b1, 1, PIX_MAX, 1, 1, 16384, 16384, 16384, 16384);
    queue_pixel(1'b1, 32768, PIX_MAX, 32768, PIX_MAX, 16384, 16384, 16384, 16384);
    queue_pixel(1'b1, 100, 100, 0, 100, 16384, 16384, 16384, 16384);
    wait_idle();

    // zero ratio: any spread is a discontinuity
    set_config(MODE_DEPTH, 16'd0);
    @(negedge clk);
    queue_pixel(1'b1, 777, 777, 777, 777, 16384, 16384, 16384, 16384);
    queue_pixel(1'b1, 777, 777, 778, 777, 16384, 16384, 16384, 16384);
    wait_idle();

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 2, 5: mode = MODE_DEPTH;
        1, 6:    mode = MODE_BILINEAR;
        3:       mode = MODE_NEAREST;
        4:       mode = MODE_SPARE;
        default: mode = MODE_BITS'($urandom_range(0, 3));
      endcase
      case (ph % 4)
        0:       ratio = RATIO_RESET;
        1:       ratio = 16'hFFFF;
        2:       ratio = RATIO_BITS'($urandom_range(0, 255));
        default: ratio = RATIO_BITS'($urandom_range(0, 65535));
      endcase
      set_config(mode, ratio);
      style = ph % 3;
      @(negedge clk);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        e.req = rand_pixel(ratio);
        case (style)
          0:       e.gap = '0;
          1:       e.gap = 4'($urandom_range(0, 9));
          default: e.gap = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 9)) : 4'd0;
        endcase
        // occasionally hold off until the pipeline has drained
        e.hold_for_drain = (n == 100) || ($urandom_range(0, 199) == 0);
        pend_q = {pend_q, e};
      end
      wait_idle();
    end

    @(negedge clk);
    if (fail_cnt == 0) begin
      $display("** lut_depth_remap_interpolator_top: PASSED **");
    end else begin
      $display("** lut_depth_remap_interpolator_top: FAILED **");
    end
    $finish;
  end

endmodule
